// ===== rtl/wsag_pkg.sv =====
// ----------------------------------------------------------------------------
// WebSocket accept generator package
// Shared payload types and constants for the key front end and hash engine.
// ----------------------------------------------------------------------------
package wsag_pkg;

  localparam int unsigned KeyLen    = 24;
  localparam int unsigned AcceptLen = 28;

  typedef struct packed {
    logic [7:0] key_byte;
    logic       key_last;
  } key_item_t;

  typedef struct packed {
    logic [7:0] accept_char;
    logic       status;
    logic       result_last;
  } accept_item_t;

  // Job handed from the front end to the hash engine
  typedef struct packed {
    logic [KeyLen*8-1:0] key;
    logic                bad;
  } job_t;

  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;

  localparam logic [287:0] Guid = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";

  function automatic logic [6:0] b64_digit(input logic [7:0] c);
    logic [6:0] r;
    r = 7'h40;
    if (c >= 8'h41 && c <= 8'h5A) r = {1'b0, 6'(c - 8'h41)};
    else if (c >= 8'h61 && c <= 8'h7A) r = {1'b0, 6'(c - 8'h61 + 8'd26)};
    else if (c >= 8'h30 && c <= 8'h39) r = {1'b0, 6'(c - 8'h30 + 8'd52)};
    else if (c == 8'h2B) r = 7'd62;
    else if (c == 8'h2F) r = 7'd63;
    return r;
  endfunction

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) r = 8'h41 + {2'b0, v};
    else if (v < 6'd52) r = 8'h61 + {2'b0, v} - 8'd26;
    else if (v < 6'd62) r = 8'h30 + {2'b0, v} - 8'd52;
    else if (v == 6'd62) r = 8'h2B;
    else r = 8'h2F;
    return r;
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

endpackage

// ===== rtl/wsag_front.sv =====
// ----------------------------------------------------------------------------
// WebSocket accept front end
// Trims blanks, stores key characters and validates the finished key.
// ----------------------------------------------------------------------------
module wsag_front
  import wsag_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  output logic      full_o,
  input  key_item_t item_i,
  output logic      job_valid_o,
  input  logic      job_ready_i,
  output job_t      job_o
);

  logic [7:0] key_q [KeyLen];
  logic [4:0] count_q;
  logic       trail_q, bad_q;
  logic       jv_q;
  job_t       job_q;
  logic       acc, blank, store, bad_now;
  logic [KeyLen*8-1:0] flat;
  logic       ok;
  logic [6:0] d21;
  logic [6:0] dg;
  logic [7:0] k23;
  logic       full_key;

  assign full_o      = jv_q && !job_ready_i;
  assign acc         = push_i && !full_o;
  assign blank       = item_i.key_byte == 8'h20 || item_i.key_byte == 8'h09;
  assign bad_now     = !blank && (trail_q || count_q >= 5'(KeyLen));
  assign store       = !blank && !bad_now;
  assign job_valid_o = jv_q;
  assign job_o       = job_q;

  always_comb begin
    flat = '0;
    for (int i = 0; i < KeyLen; i++) begin
      flat[(KeyLen-1-i)*8 +: 8] = key_q[i];
    end
    // Last byte lands in the final slot during this cycle
    if (store && count_q == 5'(KeyLen - 1)) begin
      flat[7:0] = item_i.key_byte;
    end
    // A key is complete either on its 24th character or on a trailing blank after it
    k23      = (store && count_q == 5'(KeyLen - 1)) ? item_i.key_byte : key_q[23];
    full_key = (store && count_q == 5'(KeyLen - 1)) || (blank && count_q == 5'(KeyLen));
    ok = !bad_q && !bad_now && full_key && key_q[22] == 8'h3D && k23 == 8'h3D;
    for (int i = 0; i < 22; i++) begin
      dg = b64_digit(key_q[i]);
      if (dg[6]) ok = 1'b0;
    end
    d21 = b64_digit(key_q[21]);
    if (d21[3:0] != 4'd0) ok = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (acc && store) key_q[count_q] <= item_i.key_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      trail_q <= 1'b0;
      bad_q   <= 1'b0;
      jv_q    <= 1'b0;
      job_q   <= '0;
    end else begin
      if (acc && item_i.key_last) jv_q <= 1'b1;
      else if (job_ready_i) jv_q <= 1'b0;
      if (acc) begin
        if (item_i.key_last) begin
          count_q <= '0;
          trail_q <= 1'b0;
          bad_q   <= 1'b0;
          job_q   <= '{key: flat, bad: !ok};
        end else begin
          if (blank && count_q != '0) trail_q <= 1'b1;
          if (bad_now) bad_q <= 1'b1;
          if (store) count_q <= count_q + 5'd1;
        end
      end
    end
  end

endmodule

// ===== rtl/wsag_hash.sv =====
// ----------------------------------------------------------------------------
// WebSocket accept hash engine
// Runs two SHA-1 blocks one round a cycle, then emits base64 characters.
// ----------------------------------------------------------------------------
module wsag_hash
  import wsag_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         job_valid_i,
  output logic         job_ready_o,
  input  job_t         job_i,
  output logic         empty_o,
  input  logic         pop_i,
  output accept_item_t result_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRound = 5'b00010,
    StAdd   = 5'b00100,
    StEmit  = 5'b01000,
    StErr   = 5'b10000
  } state_e;

  // Second block holds only the message length of 480 bits
  localparam logic [511:0] Blk2 = {496'h0, 16'h01E0};

  state_e      state_q;
  logic [31:0] w_q [16];
  logic [31:0] h_q [5];
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [6:0]  round_q;
  logic        sel_q;
  logic [4:0]  emit_q;
  logic [159:0] dig;
  logic [31:0] wt, f, k, tmp;
  logic [3:0]  ri;
  logic [167:0] padded;
  logic [5:0]  v;
  logic [511:0] blk1;

  assign job_ready_o = state_q == StIdle;
  assign empty_o     = !(state_q == StEmit || state_q == StErr);
  assign ri          = round_q[3:0];
  assign dig         = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
  assign padded      = {dig, 8'h00};
  assign v           = padded[167 - 6*emit_q -: 6];
  assign blk1        = {job_i.key, Guid, 8'h80, 24'h0};

  always_comb begin
    if (round_q < 7'd16) begin
      wt = w_q[ri];
    end else begin
      wt = rotl(w_q[4'(ri - 4'd3)] ^ w_q[4'(ri - 4'd8)] ^ w_q[4'(ri - 4'd14)] ^ w_q[ri], 1);
    end
    if (round_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
    end else if (round_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
    end else if (round_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
    end
    tmp = rotl(a_q, 5) + f + e_q + k + wt;
    result_o.status      = state_q == StErr;
    result_o.result_last = state_q == StErr || emit_q == 5'(AcceptLen - 1);
    if (state_q == StErr) result_o.accept_char = 8'h00;
    else if (emit_q == 5'(AcceptLen - 1)) result_o.accept_char = 8'h3D;
    else result_o.accept_char = b64_char(v);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && job_valid_i) begin
      for (int i = 0; i < 16; i++) w_q[i] <= blk1[(15-i)*32 +: 32];
    end else if (state_q == StRound) begin
      w_q[ri] <= wt;
    end else if (state_q == StAdd) begin
      for (int i = 0; i < 16; i++) w_q[i] <= Blk2[(15-i)*32 +: 32];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      round_q <= '0;
      sel_q   <= 1'b0;
      emit_q  <= '0;
      h_q     <= '{H0, H1, H2, H3, H4};
      a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            if (job_i.bad) begin
              state_q <= StErr;
            end else begin
              state_q <= StRound;
              h_q <= '{H0, H1, H2, H3, H4};
              a_q <= H0; b_q <= H1; c_q <= H2; d_q <= H3; e_q <= H4;
              round_q <= '0;
              sel_q   <= 1'b0;
            end
          end
        end
        StRound: begin
          a_q <= tmp; b_q <= a_q; c_q <= rotl(b_q, 30); d_q <= c_q; e_q <= d_q;
          round_q <= round_q + 7'd1;
          if (round_q == 7'd79) state_q <= StAdd;
        end
        StAdd: begin
          h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
          h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
          a_q <= h_q[0] + a_q; b_q <= h_q[1] + b_q; c_q <= h_q[2] + c_q;
          d_q <= h_q[3] + d_q; e_q <= h_q[4] + e_q;
          round_q <= '0;
          sel_q   <= 1'b1;
          if (sel_q) begin
            state_q <= StEmit;
            emit_q  <= '0;
          end else begin
            state_q <= StRound;
          end
        end
        StEmit: begin
          if (pop_i) begin
            emit_q <= emit_q + 5'd1;
            if (emit_q == 5'(AcceptLen - 1)) state_q <= StIdle;
          end
        end
        StErr: begin
          if (pop_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/websocket_accept_generator_unit.sv =====
// The first accept character follows the last key byte once the hash engine has run
// two SHA-1 blocks at one round per cycle; an error result skips the rounds.
// Key bytes are taken one per cycle while full is low; the rate per key is set by
// the round loop and the 28 character transfers.
// Reset clears all control state; the stored key needs no reset.
// ----------------------------------------------------------------------------
// WebSocket accept generator
// Front end validates the key, hash engine computes and encodes the accept.
// ----------------------------------------------------------------------------
module websocket_accept_generator_unit
  import wsag_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  key_item_t    item_i,
  output logic         empty,
  input  logic         pop,
  output accept_item_t result_o
);

  logic job_valid, job_ready;
  job_t job;

  wsag_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .item_i,
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  wsag_hash u_hash (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .empty_o(empty), .pop_i(pop), .result_o
  );

endmodule

// ===== bench/tb_websocket_accept_generator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket accept generator testbench
// Feeds key field values byte by byte and checks every accept character or
// error result against an in-bench SHA-1 and base64 predictor.
// ----------------------------------------------------------------------------
module tb_websocket_accept_generator_unit;
  import wsag_pkg::*;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned TailCycles = 400;

  typedef struct {
    logic [7:0] kb;
    logic       kl;
    logic       has_exp;
    logic [7:0] exp_char;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         push = 1'b0;
  logic         full;
  key_item_t    item_i = '0;
  logic         empty;
  logic         pop = 1'b0;
  accept_item_t result_o;

  accept_item_t accept_queue[$];
  logic [7:0]   key_buf[24];
  int unsigned  key_len_cnt;
  logic         blank_after, key_broken;
  int unsigned  err_count = 0;
  int unsigned  idle_cycles = 0;
  logic         rx_hold = 1'b0;
  logic         rx_hold_done = 1'b0;

  websocket_accept_generator_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .full(full), .item_i(item_i),
    .empty(empty), .pop(pop), .result_o(result_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int b64_val(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return c - "A";
    if (c >= "a" && c <= "z") return c - "a" + 26;
    if (c >= "0" && c <= "9") return c - "0" + 52;
    if (c == "+") return 62;
    if (c == "/") return 63;
    return -1;
  endfunction

  function automatic logic [7:0] b64_sym(input logic [5:0] v);
    string alpha;
    alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    return alpha[v];
  endfunction

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic sha1_compress(inout logic [31:0] h[5], input logic [7:0] msg[128],
                               input int base);
    logic [31:0] w[16];
    logic [31:0] a, b, c, d, e, f, k, t, wt;
    for (int i = 0; i < 16; i++)
      w[i] = {msg[base+4*i], msg[base+4*i+1], msg[base+4*i+2], msg[base+4*i+3]};
    a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        wt = rot_left(w[(r-3)&15] ^ w[(r-8)&15] ^ w[(r-14)&15] ^ w[r&15], 1);
        w[r&15] = wt;
      end else begin
        wt = w[r];
      end
      if (r < 20) begin f = (b & c) | (~b & d); k = 32'h5A827999; end
      else if (r < 40) begin f = b ^ c ^ d; k = 32'h6ED9EBA1; end
      else if (r < 60) begin f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC; end
      else begin f = b ^ c ^ d; k = 32'hCA62C1D6; end
      t = rot_left(a, 5) + f + e + k + wt;
      e = d; d = c; c = rot_left(b, 30); b = a; a = t;
    end
    h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
  endtask

  task automatic clear_key_state();
    key_len_cnt = 0; blank_after = 1'b0; key_broken = 1'b0;
  endtask

  function automatic logic key_valid();
    if (key_broken || key_len_cnt != 24) return 1'b0;
    if (key_buf[22] != "=" || key_buf[23] != "=") return 1'b0;
    for (int i = 0; i < 22; i++) if (b64_val(key_buf[i]) < 0) return 1'b0;
    return (b64_val(key_buf[21]) & 15) == 0;
  endfunction

  // Predict what one key byte transfer causes and queue it
  task automatic predict_accept(input key_item_t it);
    logic [7:0]  msg[128];
    logic [7:0]  dig[20];
    logic [31:0] h[5];
    logic [23:0] g;
    accept_item_t r;
    string guid;
    int n;
    guid = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";
    if (it.key_byte == " " || it.key_byte == "\t") begin
      if (key_len_cnt != 0) blank_after = 1'b1;
    end else if (blank_after || key_len_cnt >= 24) begin
      key_broken = 1'b1;
    end else begin
      key_buf[key_len_cnt] = it.key_byte;
      key_len_cnt++;
    end
    if (!it.key_last) return;
    if (!key_valid()) begin
      r.accept_char = 8'h00; r.status = 1'b1; r.result_last = 1'b1;
      accept_queue.push_back(r);
      clear_key_state();
      return;
    end
    for (int i = 0; i < 128; i++) msg[i] = 8'h00;
    for (int i = 0; i < 24; i++) msg[i] = key_buf[i];
    for (int i = 0; i < 36; i++) msg[24+i] = guid[i];
    msg[60] = 8'h80; msg[126] = 8'h01; msg[127] = 8'hE0;
    h[0] = H0; h[1] = H1; h[2] = H2; h[3] = H3; h[4] = H4;
    sha1_compress(h, msg, 0);
    sha1_compress(h, msg, 64);
    for (int i = 0; i < 20; i++) dig[i] = 8'(h[i>>2] >> (24 - 8*(i&3)));
    n = 0;
    for (int i = 0; i < 21; i += 3) begin
      g = {dig[i], dig[i+1], (i == 18) ? 8'h00 : dig[i+2]};
      for (int j = 0; j < 4; j++) begin
        r.accept_char = (i == 18 && j == 3) ? "=" : b64_sym(g[23-6*j -: 6]);
        r.status = 1'b0;
        r.result_last = (n == 27);
        accept_queue.push_back(r);
        n++;
      end
    end
    clear_key_state();
  endtask

  task automatic report_mismatch(input string what, input logic [9:0] got,
                                 input logic [9:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    err_count++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic l, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 5);
    @(negedge clk_i);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_i <= '{key_byte: b, key_last: l};
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_accept('{key_byte: b, key_last: l});
  endtask

  task automatic stop_push();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic send_string(input string s, input int pre, input int post);
    for (int i = 0; i < pre; i++) send_byte(($urandom & 1) ? " " : "\t", 1'b0, 0);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], (post == 0) && (i == s.len()-1), 0);
    for (int i = 0; i < post; i++)
      send_byte(($urandom & 1) ? " " : "\t", i == post-1, 0);
  endtask

  function automatic string rand_key();
    string s;
    s = "AAAAAAAAAAAAAAAAAAAAAA==";
    for (int i = 0; i < 21; i++) s[i] = b64_sym(6'($urandom_range(0, 63)));
    s[21] = b64_sym({2'($urandom_range(0, 3)), 4'b0});
    return s;
  endfunction

  // Receiver
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold && !rx_hold_done) begin
        pop <= 1'b0;
        repeat (400) @(negedge clk_i);
        rx_hold_done <= 1'b1;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
      if (wait_n != 0) begin
        pop <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      if (accept_queue.size() == 0) begin
        report_mismatch("unexpected result", result_o, '0);
      end else begin
        if (result_o.accept_char != accept_queue[0].accept_char)
          report_mismatch("accept_char", 10'(result_o.accept_char),
                          10'(accept_queue[0].accept_char));
        if (result_o.status != accept_queue[0].status)
          report_mismatch("status", 10'(result_o.status), 10'(accept_queue[0].status));
        if (result_o.result_last != accept_queue[0].result_last)
          report_mismatch("result_last", 10'(result_o.result_last),
                          10'(accept_queue[0].result_last));
        void'(accept_queue.pop_front());
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    string    s;
    int       kind, items, len, pre, post;
    clear_key_state();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: error cases with the result read off at once
    rows.push_back('{8'h00, 1'b1, 1'b1, 8'h00});  // lone non-base64 byte
    rows.push_back('{8'hFF, 1'b1, 1'b1, 8'h00});
    rows.push_back('{" ", 1'b1, 1'b1, 8'h00});    // empty after trimming
    rows.push_back('{"\t", 1'b0, 1'b0, 8'h00});
    rows.push_back('{"A", 1'b0, 1'b0, 8'h00});
    rows.push_back('{" ", 1'b0, 1'b0, 8'h00});    // blank then a key byte again
    rows.push_back('{"B", 1'b1, 1'b1, 8'h00});
    foreach (rows[i]) begin
      send_byte(rows[i].kb, rows[i].kl, 0);
      if (rows[i].has_exp) begin
        if (accept_queue[accept_queue.size()-1].accept_char != rows[i].exp_char)
          report_mismatch("directed row", 10'(accept_queue[accept_queue.size()-1]),
                          {rows[i].exp_char, 2'b11});
        accept_queue[accept_queue.size()-1] =
          '{accept_char: rows[i].exp_char, status: 1'b1, result_last: 1'b1};
      end
    end
    // Well-known key, plus trimmed, over-long and bad-padding variants
    send_string("dGhlIHNhbXBsZSBub25jZQ==", 0, 0);
    send_string("dGhlIHNhbXBsZSBub25jZQ==", 2, 2);
    send_string("dGhlIHNhbXBsZSBub25jZQ==A", 0, 0);
    send_string("dGhlIHNhbXBsZSBub25jZR==", 0, 0);
    send_string("//////////////////////w=", 0, 0);
    send_string("++++++++++++++++++++++==", 1, 0);
    stop_push();

    // Sender pauses until the queue drains
    while (accept_queue.size() != 0) @(negedge clk_i);

    items = 0;
    while (items < 250) begin
      if (items > 100 && items < 160 && !rx_hold) begin
        rx_hold <= 1'b1;
      end
      kind = $urandom_range(0, 9);
      s = rand_key();
      if (kind == 0) begin
        s = "";
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) s = {s, "A"};
        for (int i = 0; i < s.len(); i++) s[i] = 8'($urandom_range(1, 255));
      end else if (kind == 1) begin
        s[$urandom_range(0, 23)] = 8'($urandom_range(1, 255));
      end
      pre  = $urandom_range(0, 2);
      post = $urandom_range(0, 2);
      send_string(s, pre, post);
      items += s.len() + pre + post;
    end
    stop_push();

    while (accept_queue.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (err_count == 0 && accept_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
